// ===== design/cdhs_pkg.sv =====
// Shared constants, payload types and tables for the concentric disk sampler.
package cdhs_pkg;

	localparam int IFB = 16;            // input fraction bits
	localparam int OFB = 15;            // output fraction bits
	localparam int QW = 31;             // quotient bits of the angle divider and the radius
	localparam int NW = IFB + QW;       // dividend width
	localparam int CW = 33;             // CORDIC datapath width, Q2.30 plus headroom
	localparam int CORDIC_STAGES = 28;
	localparam int SQ_STEPS = OFB + 1;  // root bits of the height
	localparam int RAD_W = 2 * SQ_STEPS;
	localparam int REM_W = SQ_STEPS + 2;
	localparam int SH = 30 - OFB;

	localparam logic [IFB-1:0] DMAX = '1;
	localparam logic [29:0] PI4_Q30 = 30'd843314857;
	localparam logic [29:0] KINV_Q30 = 30'd652032874;
	localparam int ONE_HI = (1 << OFB) - 1;

	typedef struct packed {
		logic [IFB-1:0] sample_u;
		logic [IFB-1:0] sample_v;
	} sample_t;

	typedef struct packed {
		logic signed [OFB:0] point_x;
		logic signed [OFB:0] point_y;
		logic [OFB-1:0] point_z;
	} point_t;

	typedef struct packed {
		logic center;
		logic [1:0] axis;
		logic neg;
	} tag_t;

	typedef struct packed {
		tag_t tag;
		logic [IFB-1:0] den;
		logic [IFB-1:0] a_rem;
		logic [QW-1:0] a_low;
		logic [QW-1:0] rq;
	} div_t;

	typedef struct packed {
		tag_t tag;
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic signed [CW-1:0] z;
	} cord_t;

	typedef struct packed {
		logic center;
		logic signed [OFB:0] qx;
		logic signed [OFB:0] qy;
		logic [REM_W-1:0] rem;
		logic [SQ_STEPS-1:0] root;
		logic [RAD_W-1:0] rad;
	} sqrt_t;

	// arctangent of 2^-i in Q2.30 radians
	function automatic logic signed [CW-1:0] atan_q30(input int i);
		logic [31:0] v;
		case (i)
			0: v = 32'd843314857;
			1: v = 32'd497837830;
			2: v = 32'd263043837;
			3: v = 32'd133525159;
			4: v = 32'd67021687;
			5: v = 32'd33543515;
			6: v = 32'd16775850;
			7: v = 32'd8388437;
			8: v = 32'd4194283;
			9: v = 32'd2097149;
			10: v = 32'd1048576;
			11: v = 32'd524288;
			12: v = 32'd262144;
			13: v = 32'd131072;
			14: v = 32'd65536;
			15: v = 32'd32768;
			16: v = 32'd16384;
			17: v = 32'd8192;
			18: v = 32'd4096;
			19: v = 32'd2048;
			20: v = 32'd1024;
			21: v = 32'd512;
			22: v = 32'd256;
			23: v = 32'd128;
			24: v = 32'd64;
			25: v = 32'd32;
			26: v = 32'd16;
			27: v = 32'd8;
			default: v = 32'd0;
		endcase
		return $signed({1'b0, v});
	endfunction

endpackage

// ===== design/cdhs_div_cell.sv =====
// One restoring step of the angle divider; the radius rides along.
module cdhs_div_cell
	import cdhs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic v_in,
	input  div_t d,
	output logic v_out,
	output div_t q
);

	logic [IFB:0] a_t, a_n;
	logic a_ge;
	div_t nx;

	always_comb begin
		a_t = {d.a_rem, d.a_low[QW-1]};
		a_ge = a_t >= {1'b0, d.den};
		a_n = a_ge ? a_t - {1'b0, d.den} : a_t;
		nx = d;
		nx.a_rem = a_n[IFB-1:0];
		nx.a_low = {d.a_low[QW-2:0], a_ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nx;
		end
	end

endmodule

// ===== design/cdhs_cordic_cell.sv =====
// One CORDIC rotation stage.
module cdhs_cordic_cell
	import cdhs_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic v_in,
	input  cord_t d,
	output logic v_out,
	output cord_t q
);

	localparam logic signed [CW-1:0] ATAN = atan_q30(IDX);

	logic signed [CW-1:0] dx, dy;
	cord_t nx;

	always_comb begin
		dx = d.y >>> IDX;
		dy = d.x >>> IDX;
		nx = d;
		// rotate toward zero residual angle
		if (d.z >= 0) begin
			nx.x = d.x - dx;
			nx.y = d.y + dy;
			nx.z = d.z - ATAN;
		end else begin
			nx.x = d.x + dx;
			nx.y = d.y - dy;
			nx.z = d.z + ATAN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nx;
		end
	end

endmodule

// ===== design/cdhs_sqrt_cell.sv =====
// One digit step of the integer square root for the height.
module cdhs_sqrt_cell
	import cdhs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic v_in,
	input  sqrt_t d,
	output logic v_out,
	output sqrt_t q
);

	logic [REM_W+1:0] r2, trial, r_n;
	logic ge;
	sqrt_t nx;

	always_comb begin
		r2 = {d.rem, d.rad[RAD_W-1 -: 2]};
		trial = (REM_W + 2)'({d.root, 2'b01});
		ge = r2 >= trial;
		r_n = ge ? r2 - trial : r2;
		nx = d;
		nx.rem = r_n[REM_W-1:0];
		nx.root = {d.root[SQ_STEPS-2:0], ge};
		nx.rad = {d.rad[RAD_W-3:0], 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_out <= 1'b0;
		end else if (en) begin
			v_out <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nx;
		end
	end

endmodule

// ===== design/concentric_disk_hemisphere_sampler.sv =====
// Throughput: one item per cycle while the output buffer's second entry is free;
// the chain of divider, CORDIC and root cells advances together, and a
// two-entry output buffer keeps it moving while one result waits. Reset clears
// every valid bit, including those of the output buffer, and sets mode_q to 1;
// the configuration port is always ready.
module concentric_disk_hemisphere_sampler
	import cdhs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic sample_valid,
	output logic sample_ready,
	input  sample_t sample,
	output logic point_valid,
	input  logic point_ready,
	output point_t point,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_data
);

	logic en;
	logic mode_q;

	// configuration
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b1;
		end else if (cfg_valid) begin
			mode_q <= cfg_data;
		end
	end

	// wedge selection
	logic signed [IFB+1:0] a_w, b_w, num_w, den_w, mag_w;
	logic signed [IFB+2:0] sum_w, diff_w;
	tag_t tag_w;

	always_comb begin
		a_w = $signed({1'b0, sample.sample_u, 1'b0}) - $signed({2'b00, DMAX});
		b_w = $signed({1'b0, sample.sample_v, 1'b0}) - $signed({2'b00, DMAX});
		sum_w = (IFB + 3)'(a_w) + (IFB + 3)'(b_w);
		diff_w = (IFB + 3)'(a_w) - (IFB + 3)'(b_w);
		if (sum_w >= 0) begin
			if (diff_w > 0) begin
				num_w = b_w;
				den_w = a_w;
				tag_w.axis = 2'd0;
			end else begin
				num_w = -a_w;
				den_w = b_w;
				tag_w.axis = 2'd1;
			end
		end else begin
			if (diff_w <= 0) begin
				num_w = -b_w;
				den_w = -a_w;
				tag_w.axis = 2'd2;
			end else begin
				num_w = a_w;
				den_w = -b_w;
				tag_w.axis = 2'd3;
			end
		end
		mag_w = (num_w < 0) ? -num_w : num_w;
		tag_w.neg = num_w < 0;
		tag_w.center = (a_w == 0) && (b_w == 0);
	end

	logic v_s1;
	logic [IFB-1:0] mag_s1, den_s1;
	tag_t tag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= sample_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= mag_w[IFB-1:0];
			den_s1 <= den_w[IFB-1:0];
			tag_s1 <= tag_w;
		end
	end

	// divider setup: rounded angle dividend and the rounded radius
	logic [IFB+29:0] pa_w;
	logic [NW-1:0] na_w;
	logic [QW-1:0] dq_w, nq_w, rq_w;
	logic [IFB:0] hl_w;
	div_t div_w [0:QW];
	logic div_v [0:QW];
	div_t div_s2;
	logic v_s2;

	always_comb begin
		pa_w = (IFB + 30)'(mag_s1) * (IFB + 30)'(PI4_Q30);
		na_w = NW'(pa_w) + NW'(den_s1 >> 1);
		// den * 2^30 / D splits into den * 2^(30-IFB) plus a short quotient by D,
		// and with D = 2^IFB - 1 that quotient is hi + (hi + lo >= D)
		dq_w = QW'({den_s1, (30 - IFB)'(0)});
		nq_w = dq_w + QW'(DMAX >> 1);
		hl_w = (IFB + 1)'(nq_w[QW-1:IFB]) + (IFB + 1)'(nq_w[IFB-1:0]);
		rq_w = dq_w + QW'(nq_w[QW-1:IFB]) + QW'(hl_w >= {1'b0, DMAX});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s2.tag <= tag_s1;
			div_s2.den <= den_s1;
			div_s2.a_rem <= na_w[NW-1:QW];
			div_s2.a_low <= na_w[QW-1:0];
			div_s2.rq <= rq_w;
		end
	end

	assign div_w[0] = div_s2;
	assign div_v[0] = v_s2;

	for (genvar i = 0; i < QW; i++) begin : g_div
		cdhs_div_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.v_in(div_v[i]),
			.d(div_w[i]),
			.v_out(div_v[i+1]),
			.q(div_w[i+1])
		);
	end

	// gain-corrected radius and signed angle
	logic [QW+29:0] pr_w;
	logic [QW+29:0] prr_w;
	logic signed [CW-1:0] ang_w;
	cord_t cord_w [0:CORDIC_STAGES];
	logic cord_v [0:CORDIC_STAGES];
	cord_t cord_s3;
	logic v_s3;

	always_comb begin
		pr_w = (QW + 30)'(div_w[QW].rq) * (QW + 30)'(KINV_Q30);
		prr_w = pr_w + (QW + 30)'(1 << 29);
		ang_w = CW'({1'b0, div_w[QW].a_low});
		if (div_w[QW].tag.neg) begin
			ang_w = -ang_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= div_v[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cord_s3.tag <= div_w[QW].tag;
			cord_s3.x <= CW'({1'b0, prr_w[QW+29:30]});
			cord_s3.y <= '0;
			cord_s3.z <= ang_w;
		end
	end

	assign cord_w[0] = cord_s3;
	assign cord_v[0] = v_s3;

	for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
		cdhs_cordic_cell #(
			.IDX(i)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.v_in(cord_v[i]),
			.d(cord_w[i]),
			.v_out(cord_v[i+1]),
			.q(cord_w[i+1])
		);
	end

	// quarter turn to the wedge axis, round and clamp to Q1.OFB
	function automatic logic signed [OFB:0] to_q(input logic signed [CW-1:0] v);
		logic signed [CW-1:0] t;
		t = (v + CW'(1 << (SH - 1))) >>> SH;
		if (t > CW'(ONE_HI)) begin
			t = CW'(ONE_HI);
		end else if (t < -CW'(ONE_HI + 1)) begin
			t = -CW'(ONE_HI + 1);
		end
		return t[OFB:0];
	endfunction

	logic signed [CW-1:0] rx_w, ry_w, c_w, s_w;
	logic signed [OFB:0] qx_s4, qy_s4;
	logic center_s4, v_s4;

	always_comb begin
		c_w = cord_w[CORDIC_STAGES].x;
		s_w = cord_w[CORDIC_STAGES].y;
		case (cord_w[CORDIC_STAGES].tag.axis)
			2'd0: begin
				rx_w = c_w;
				ry_w = s_w;
			end
			2'd1: begin
				rx_w = -s_w;
				ry_w = c_w;
			end
			2'd2: begin
				rx_w = -c_w;
				ry_w = -s_w;
			end
			default: begin
				rx_w = s_w;
				ry_w = -c_w;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= cord_v[CORDIC_STAGES];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qx_s4 <= to_q(rx_w);
			qy_s4 <= to_q(ry_w);
			center_s4 <= cord_w[CORDIC_STAGES].tag.center;
		end
	end

	// squares for the height
	logic signed [RAD_W-1:0] sx_w, sy_w;
	logic [RAD_W-1:0] sx_s5, sy_s5;
	logic signed [OFB:0] qx_s5, qy_s5;
	logic center_s5, v_s5;

	always_comb begin
		sx_w = RAD_W'(qx_s4) * RAD_W'(qx_s4);
		sy_w = RAD_W'(qy_s4) * RAD_W'(qy_s4);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sx_s5 <= sx_w;
			sy_s5 <= sy_w;
			qx_s5 <= qx_s4;
			qy_s5 <= qy_s4;
			center_s5 <= center_s4;
		end
	end

	localparam logic [RAD_W:0] ONE_SQ = (RAD_W + 1)'(1) << (2 * OFB);

	logic signed [RAD_W+1:0] s_rad_w;
	sqrt_t sq_in_w;
	sqrt_t sq_w [0:SQ_STEPS];
	logic sq_v [0:SQ_STEPS];

	always_comb begin
		s_rad_w = $signed({1'b0, ONE_SQ}) - $signed({2'b00, sx_s5})
			- $signed({2'b00, sy_s5});
		sq_in_w.center = center_s5;
		sq_in_w.qx = qx_s5;
		sq_in_w.qy = qy_s5;
		sq_in_w.rem = '0;
		sq_in_w.root = '0;
		// drop to zero height outside the unit disk
		sq_in_w.rad = (s_rad_w > 0) ? s_rad_w[RAD_W-1:0] : '0;
	end

	assign sq_w[0] = sq_in_w;
	assign sq_v[0] = v_s5;

	for (genvar i = 0; i < SQ_STEPS; i++) begin : g_sqrt
		cdhs_sqrt_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.en(en),
			.v_in(sq_v[i]),
			.d(sq_w[i]),
			.v_out(sq_v[i+1]),
			.q(sq_w[i+1])
		);
	end

	// round the root, apply mode and the center case
	logic [SQ_STEPS:0] rnd_w;
	logic [OFB-1:0] zq_w;
	point_t res_w, res_s6;
	logic v_s6;

	always_comb begin
		rnd_w = {1'b0, sq_w[SQ_STEPS].root}
			+ (SQ_STEPS + 1)'(sq_w[SQ_STEPS].rem > REM_W'(sq_w[SQ_STEPS].root));
		zq_w = (rnd_w > (SQ_STEPS + 1)'(ONE_HI)) ? OFB'(ONE_HI) : rnd_w[OFB-1:0];
		if (sq_w[SQ_STEPS].center) begin
			res_w.point_x = '0;
			res_w.point_y = '0;
			res_w.point_z = mode_q ? OFB'(ONE_HI) : '0;
		end else begin
			res_w.point_x = sq_w[SQ_STEPS].qx;
			res_w.point_y = sq_w[SQ_STEPS].qy;
			res_w.point_z = mode_q ? zq_w : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= sq_v[SQ_STEPS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_s6 <= res_w;
		end
	end

	// two-entry output buffer
	logic out_v_q, skid_v_q;
	point_t out_q, skid_q;
	logic pop, push;

	assign en = !skid_v_q;
	assign sample_ready = en;
	assign pop = out_v_q && point_ready;
	assign push = en && v_s6;
	assign point_valid = out_v_q;
	assign point = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (push && out_v_q && !pop) begin
			skid_v_q <= 1'b1;
		end else if (push) begin
			out_v_q <= 1'b1;
		end else if (pop) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push && out_v_q && !pop) begin
			skid_q <= res_s6;
		end else if (push) begin
			out_q <= res_s6;
		end
	end

endmodule
